@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the overcurrent trip unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define OCT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define OCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/oct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oct_pkg
// Shared constants and types of the channel overcurrent trip unit.
// ----------------------------------------------------------------------------
package oct_pkg;

   localparam int CHANNELS            = 14;
   localparam int HIGH_POWER_CHANNELS = 4;
   localparam int ADC_BITS            = 10;

   localparam int CH_W     = 4;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int GAIN_W   = 16;
   localparam int LEVEL_W  = 18;
   localparam int TIME_W   = 32;
   localparam int CUR_W    = 18;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = ADC_BITS + GAIN_W;
   localparam int SCALED_W = PROD_W - FRAC_W;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CUR_W-1:0]   CUR_MAX           = '1;
   localparam logic [GAIN_W-1:0]  GAIN_RESET        = GAIN_W'(256);
   localparam logic [LEVEL_W-1:0] LEVEL_RESET       = '1;
   localparam logic [TIME_W-1:0]  TRIP_DELAY_RESET  = TIME_W'(1000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HP_GAIN  = 3'd0,
      CSR_LP_GAIN  = 3'd1,
      CSR_HP_LEVEL = 3'd2,
      CSR_LP_LEVEL = 3'd3,
      CSR_DELAY    = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      STATUS_OFF   = 2'd0,
      STATUS_ON    = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  hp_gain;
      logic [GAIN_W-1:0]  lp_gain;
      logic [LEVEL_W-1:0] hp_level;
      logic [LEVEL_W-1:0] lp_level;
      logic [TIME_W-1:0]  delay;
   } cfg_type;

   // sample after the gain multiply
   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic              hp;
      logic              enabled;
      logic [TIME_W-1:0] now;
      logic [PROD_W-1:0] product;
   } scaled_type;

   // lowest field last so the packed struct maps straight onto tdata
   typedef struct packed {
      logic             any_tripped;
      logic             drive;
      status_type       status;
      logic [CUR_W-1:0] current_ma;
   } result_type;

endpackage

@@ sv/oct_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oct_csr
// Configuration registers: gains, trip levels and trip delay.
// ----------------------------------------------------------------------------
module oct_csr
   import oct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hp_gain  <= GAIN_RESET;
         cfg_ff.lp_gain  <= GAIN_RESET;
         cfg_ff.hp_level <= LEVEL_RESET;
         cfg_ff.lp_level <= LEVEL_RESET;
         cfg_ff.delay    <= TRIP_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HP_GAIN: begin
               cfg_ff.hp_gain <= csr_data[GAIN_W-1:0];
            end
            CSR_LP_GAIN: begin
               cfg_ff.lp_gain <= csr_data[GAIN_W-1:0];
            end
            CSR_HP_LEVEL: begin
               cfg_ff.hp_level <= csr_data[LEVEL_W-1:0];
            end
            CSR_LP_LEVEL: begin
               cfg_ff.lp_level <= csr_data[LEVEL_W-1:0];
            end
            CSR_DELAY: begin
               cfg_ff.delay <= csr_data[TIME_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ sv/oct_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oct_scale
// Input register and gain multiply, product registered for the trip stage.
// ----------------------------------------------------------------------------
module oct_scale
   import oct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CH_W-1:0]     in_channel,
   input  logic [ADC_BITS-1:0] in_adc_code,
   input  logic                in_enabled,
   input  logic [TIME_W-1:0]   in_now,
   input  cfg_type             cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output scaled_type          out_item
);

   logic                s1_valid_ff;
   logic [CH_W-1:0]     s1_channel_ff;
   logic [ADC_BITS-1:0] s1_adc_ff;
   logic                s1_enabled_ff;
   logic [TIME_W-1:0]   s1_now_ff;

   logic                s2_valid_ff;
   scaled_type          s2_item_ff;
   scaled_type          s2_item_in;

   logic                s1_load;
   logic                s2_load;
   logic                hp;
   logic [GAIN_W-1:0]   gain;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

   always_comb begin
      hp   = (32'(s1_channel_ff) < HIGH_POWER_CHANNELS);
      gain = hp ? cfg.hp_gain : cfg.lp_gain;
      s2_item_in.channel = s1_channel_ff;
      s2_item_in.hp      = hp;
      s2_item_in.enabled = s1_enabled_ff;
      s2_item_in.now     = s1_now_ff;
      s2_item_in.product = PROD_W'(s1_adc_ff) * PROD_W'(gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && in_valid) begin
         s1_channel_ff <= in_channel;
         s1_adc_ff     <= in_adc_code;
         s1_enabled_ff <= in_enabled;
         s1_now_ff     <= in_now;
      end
      if (s2_load && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

endmodule

@@ sv/oct_trip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oct_trip
// Per-channel last-ok times and short latches, trip decision and result.
// ----------------------------------------------------------------------------
module oct_trip
   import oct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  scaled_type item,
   input  cfg_type    cfg,
   output result_type result,
   output logic       latch_any
);

   logic [TIME_W-1:0]   last_ok_ff [CHANNELS];
   logic [CHANNELS-1:0] latch_ff;

   logic                in_range;
   logic [CH_IDX_W-1:0] idx;
   logic [SCALED_W-1:0] scaled;
   logic [CUR_W-1:0]    cur;
   logic [LEVEL_W-1:0]  level;
   logic                ok;
   logic [TIME_W-1:0]   elapsed;
   logic                set;
   logic                latched;

   always_comb begin
      in_range = (32'(item.channel) < CHANNELS);
      idx      = in_range ? item.channel[CH_IDX_W-1:0] : '0;
      scaled   = item.product[PROD_W-1:FRAC_W];
      cur      = (scaled > CUR_MAX) ? CUR_MAX : CUR_W'(scaled);
      level    = item.hp ? cfg.hp_level : cfg.lp_level;
      // a healthy sample refreshes last-ok, so elapsed only counts when not ok
      ok       = (cur < level) || !item.enabled;
      elapsed  = item.now - last_ok_ff[idx];
      set      = in_range && !ok && (elapsed > cfg.delay);
      latched  = latch_ff[idx] || set;

      result.any_tripped = (|latch_ff) || set;
      if (!in_range) begin
         result.current_ma = '0;
         result.status     = STATUS_OFF;
         result.drive      = 1'b0;
      end else if (latched) begin
         result.current_ma = '0;
         result.status     = STATUS_SHORT;
         result.drive      = 1'b1;
      end else begin
         result.current_ma = cur;
         result.status     = item.enabled ? STATUS_ON : STATUS_OFF;
         result.drive      = item.enabled;
      end
   end

   assign latch_any = |latch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_ok_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         if (ok) begin
            last_ok_ff[idx] <= item.now;
         end
         if (set) begin
            latch_ff[idx] <= 1'b1;
         end
      end
   end

endmodule

@@ sv/channel_overcurrent_trip_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_overcurrent_trip_unit
// Per-channel overcurrent protection with a trip delay and sticky short latch.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    channel, adc_code, channel_enabled, now_ticks
//  rsp_     out  rsp_tvalid/tready    current_ma, channel_status, drive, any_tripped
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
// one word per cycle sustained while rsp is not stalled; a word accepted on req
// is offered on rsp after the input, product and result registers, since the
// gain multiply is registered ahead of the per-channel trip logic.
// synchronous active-high reset clears all latches and last-ok times and loads
// the register defaults. a stalled rsp backs up stage by stage, req_tready
// drops only once every stage holds a word. csr writes are taken every cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module channel_overcurrent_trip_unit
   import oct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [3:0] channel, [13:4] adc_code, [14] channel_enabled, [46:15] now_ticks
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [17:0] current_ma, [19:18] channel_status, [20] drive, [21] any_tripped
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADC_LSB = CH_W;
   localparam int EN_BIT  = ADC_LSB + ADC_BITS;
   localparam int NOW_LSB = EN_BIT + 1;

   cfg_type    cfg;
   scaled_type scaled_item;
   result_type result;
   logic       scaled_valid;
   logic       latch_any;
   logic       rsp_load;
   logic       trip_fire;

   logic       rsp_valid_ff;
   result_type rsp_result_ff;

   oct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   oct_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_channel  (req_tdata[CH_W-1:0]),
      .in_adc_code (req_tdata[EN_BIT-1:ADC_LSB]),
      .in_enabled  (req_tdata[EN_BIT]),
      .in_now      (req_tdata[NOW_LSB+TIME_W-1:NOW_LSB]),
      .cfg         (cfg),
      .out_valid   (scaled_valid),
      .out_ready   (rsp_load),
      .out_item    (scaled_item)
   );

   oct_trip u_trip (
      .clock     (clock),
      .reset     (reset),
      .advance   (trip_fire),
      .item      (scaled_item),
      .cfg       (cfg),
      .result    (result),
      .latch_any (latch_any)
   );

   assign rsp_load  = !rsp_valid_ff || rsp_tready;
   assign trip_fire = scaled_valid && rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= scaled_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (trip_fire) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_result_ff);

   // short latches only clear on reset
   `OCT_ASSERT_NEXT(a_latch_sticky, latch_any, latch_any, "short latch cleared without reset")
   `OCT_ASSERT_IMPL(a_short_drives, rsp_valid_ff && (rsp_result_ff.status == STATUS_SHORT),
      rsp_result_ff.drive && rsp_result_ff.any_tripped && (rsp_result_ff.current_ma == '0),
      "short word without drive, any_tripped or zero current")
   `OCT_ASSERT_IMPL(a_undriven_off, rsp_valid_ff && !rsp_result_ff.drive,
      rsp_result_ff.status == STATUS_OFF, "undriven channel not reported off")

endmodule

@@ test/channel_trip_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_trip_checker
// Watches the sample, report and register channels of the overcurrent trip
// unit, keeps its own copy of the per-channel last-ok times, short latches and
// register settings, predicts the report for every accepted sample word and
// compares each accepted report word field by field, in order.
// ----------------------------------------------------------------------------
module channel_trip_checker
   import oct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     outstanding
);

   logic [GAIN_W-1:0]   hp_gain;
   logic [GAIN_W-1:0]   lp_gain;
   logic [LEVEL_W-1:0]  hp_level;
   logic [LEVEL_W-1:0]  lp_level;
   logic [TIME_W-1:0]   trip_delay;
   logic [TIME_W-1:0]   last_ok_at [CHANNELS];
   logic [CHANNELS-1:0] latched;

   result_type predicted_reports [$];
   result_type want;
   result_type got;
   int         mismatches = 0;

   assign fail_count = mismatches;

   // updates the channel state for one sample and returns its report
   function automatic result_type assess_sample(input logic [CH_W-1:0] ch,
                                                input logic [ADC_BITS-1:0] code,
                                                input logic en,
                                                input logic [TIME_W-1:0] now);
      result_type        report;
      longint unsigned   scaled;
      logic [GAIN_W-1:0] gain;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0] over_for;
      report = '0;
      report.status = STATUS_OFF;
      if (ch < CHANNELS) begin
         if (ch < HIGH_POWER_CHANNELS) begin
            gain  = hp_gain;
            level = hp_level;
         end else begin
            gain  = lp_gain;
            level = lp_level;
         end
         scaled = (longint'(code) * longint'(gain)) >> FRAC_W;
         if (scaled > CUR_MAX)
            scaled = CUR_MAX;
         // compare uses the scaled value, before a set latch forces zero
         if (scaled < level || !en)
            last_ok_at[ch] = now;
         over_for = now - last_ok_at[ch];
         if (over_for > trip_delay)
            latched[ch] = 1'b1;
         if (latched[ch]) begin
            report.status = STATUS_SHORT;
         end else begin
            report.current_ma = CUR_W'(scaled);
            report.status     = en ? STATUS_ON : STATUS_OFF;
         end
         report.drive = en | latched[ch];
      end
      report.any_tripped = |latched;
      return report;
   endfunction

   function automatic void compare_field(input string field, input int unsigned expected,
                                         input int unsigned actual);
      if (expected != actual) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
                  actual);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         hp_gain    = GAIN_RESET;
         lp_gain    = GAIN_RESET;
         hp_level   = LEVEL_RESET;
         lp_level   = LEVEL_RESET;
         trip_delay = TRIP_DELAY_RESET;
         latched    = '0;
         for (int i = 0; i < CHANNELS; i++)
            last_ok_at[i] = '0;
         predicted_reports.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HP_GAIN:  hp_gain    = csr_data[GAIN_W-1:0];
               CSR_LP_GAIN:  lp_gain    = csr_data[GAIN_W-1:0];
               CSR_HP_LEVEL: hp_level   = csr_data[LEVEL_W-1:0];
               CSR_LP_LEVEL: lp_level   = csr_data[LEVEL_W-1:0];
               CSR_DELAY:    trip_delay = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predicted_reports.push_back(assess_sample(req_tdata[3:0], req_tdata[13:4],
                                                      req_tdata[14], req_tdata[46:15]));
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (predicted_reports.size() == 0) begin
               mismatches++;
               $display("%0t: report word with none expected, actual current %0d status %0d",
                        $time, got.current_ma, got.status);
            end else begin
               want = predicted_reports.pop_front();
               compare_field("current_ma", want.current_ma, got.current_ma);
               compare_field("channel_status", want.status, got.status);
               compare_field("drive", want.drive, got.drive);
               compare_field("any_tripped", want.any_tripped, got.any_tripped);
            end
         end
         outstanding <= predicted_reports.size();
      end
   end

endmodule

@@ test/tb_channel_overcurrent_trip_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_overcurrent_trip_unit
// Drives sample words and register writes into the overcurrent trip unit:
// a directed run over channel classes, thresholds, zero delay, time wrap and
// unused register indexes, then random phases under several settings, most with
// random stalls on both streams. The checker predicts and compares reports.
// ----------------------------------------------------------------------------
module tb_channel_overcurrent_trip_unit;
   import oct_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int PHASE_SAMPLES  = 75;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   logic steady_flow = 1'b0;
   int   fail_count;
   int   outstanding;
   int   quiet_cycles = 0;

   channel_overcurrent_trip_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   channel_trip_checker trip_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock)
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 25);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [ADC_BITS-1:0] code,
                              input logic en, input logic [TIME_W-1:0] now);
      if (!steady_flow && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 25);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, now, en, code, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drains the unit, then rewrites every register; unused bits carry noise
   task automatic load_settings(input logic [GAIN_W-1:0] hp_g, input logic [GAIN_W-1:0] lp_g,
                                input logic [LEVEL_W-1:0] hp_l, input logic [LEVEL_W-1:0] lp_l,
                                input logic [TIME_W-1:0] dly);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      write_reg(CSR_HP_GAIN, {16'($urandom), hp_g});
      write_reg(CSR_LP_GAIN, {16'($urandom), lp_g});
      write_reg(CSR_HP_LEVEL, {14'($urandom), hp_l});
      write_reg(CSR_LP_LEVEL, {14'($urandom), lp_l});
      write_reg(CSR_DELAY, dly);
      // an unused index must leave every register alone
      write_reg(CSR_INDEX_W'(CSR_DELAY) + CSR_INDEX_W'($urandom_range(1, 3)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // level between 20 and 100 percent of the top reachable current
   function automatic logic [LEVEL_W-1:0] level_for(input logic [GAIN_W-1:0] gain);
      longint unsigned top_ma;
      top_ma = (((longint'(1) << ADC_BITS) - 1) * longint'(gain)) >> FRAC_W;
      return LEVEL_W'(top_ma * $urandom_range(20, 100) / 100);
   endfunction

   initial begin
      logic [GAIN_W-1:0]   hp_g;
      logic [GAIN_W-1:0]   lp_g;
      logic [LEVEL_W-1:0]  hp_l;
      logic [LEVEL_W-1:0]  lp_l;
      logic [TIME_W-1:0]   dly;
      logic [CH_W-1:0]     ch;
      logic [ADC_BITS-1:0] code;
      logic                en;
      logic [TIME_W-1:0]   ticks;
      int                  pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings: nothing can reach the trip level
      send_sample(4'd0, 10'd0, 1'b0, 32'd0);
      send_sample(4'd3, 10'd1023, 1'b1, 32'd1);
      send_sample(4'd4, 10'd1023, 1'b1, 32'd2);
      send_sample(4'd13, 10'd1, 1'b0, 32'd3);
      send_sample(4'd14, 10'd1023, 1'b1, 32'd4);
      send_sample(4'd15, 10'd0, 1'b0, 32'd5);

      load_settings(16'hFFFF, 16'h0200, 18'd100000, 18'd1000, 32'd0);
      // zero delay: trips only once time moves past last ok
      send_sample(4'd2, 10'd0, 1'b1, 32'd10);
      send_sample(4'd2, 10'd1023, 1'b1, 32'd10);
      send_sample(4'd2, 10'd1023, 1'b1, 32'd11);
      send_sample(4'd2, 10'd0, 1'b0, 32'd12);
      send_sample(4'd14, 10'd5, 1'b1, 32'd13);
      send_sample(4'd6, 10'd400, 1'b1, 32'd14);
      // disabled while over the level, then exactly at the level
      send_sample(4'd7, 10'd1023, 1'b0, 32'd15);
      send_sample(4'd7, 10'd500, 1'b1, 32'd15);
      send_sample(4'd7, 10'd499, 1'b1, 32'd16);
      // time wrap between ok and overcurrent
      send_sample(4'd12, 10'd0, 1'b1, 32'hFFFF_FFFF);
      send_sample(4'd12, 10'd1023, 1'b1, 32'd0);
      send_sample(4'd2, 10'd1023, 1'b1, 32'd20);
      send_sample(4'd3, 10'd100, 1'b1, 32'd21);
      send_sample(4'd4, 10'd100, 1'b1, 32'd22);

      ticks = 32'hFFFF_F000;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               hp_g = GAIN_W'($urandom);
               lp_g = GAIN_W'($urandom);
               hp_l = '1;
               lp_l = '1;
               dly  = '1;
            end
            1: begin
               hp_g = '1;
               lp_g = '0;
               hp_l = level_for(hp_g);
               lp_l = '0;
               dly  = $urandom_range(1000, 5000);
            end
            2: begin
               hp_g = '0;
               lp_g = '1;
               hp_l = LEVEL_W'($urandom);
               lp_l = level_for(lp_g);
               dly  = $urandom_range(100, 3000);
            end
            default: begin
               hp_g = GAIN_W'($urandom);
               lp_g = GAIN_W'($urandom);
               hp_l = level_for(hp_g);
               lp_l = level_for(lp_g);
               dly  = (phase == PHASES - 1) ? '0 : $urandom_range(20, 3000);
            end
         endcase
         load_settings(hp_g, lp_g, hp_l, lp_l, dly);
         steady_flow <= (phase == 2);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            ch = ($urandom_range(0, 99) < 6) ? CH_W'($urandom_range(CHANNELS, 15))
                                             : CH_W'($urandom_range(0, CHANNELS - 1));
            pick = $urandom_range(0, 9);
            code = (pick == 0) ? '0 : (pick == 1) ? '1 : ADC_BITS'($urandom);
            en = ($urandom_range(0, 99) < 80);
            if ($urandom_range(0, 99) < 3)
               ticks = ticks + $urandom;
            else
               ticks = ticks + $urandom_range(0, 40);
            send_sample(ch, code, en, ticks);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ channel_overcurrent_trip_unit.f @@
+incdir+sv
sv/oct_pkg.sv
sv/oct_csr.sv
sv/oct_scale.sv
sv/oct_trip.sv
sv/channel_overcurrent_trip_unit.sv
test/channel_trip_checker.sv
test/tb_channel_overcurrent_trip_unit.sv
